// ===== design/aag_pkg.sv =====
// Shared constants and types for the allocation alignment selector.
// Used by aag_div, allocation_alignment_select and aag_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aag_pkg;

    // Port widths, fixed by the transaction fields
    localparam int SIZE_W  = 48;
    localparam int REQ_W   = 20;
    localparam int OUT_W   = 48;

    // Operand width of the shared divider: every gcd operand stays below 2^32
    localparam int DIV_W   = 32;
    localparam int PROD_W  = 2 * DIV_W;

    localparam logic [OUT_W-1:0] MASK48 = {OUT_W{1'b1}};

    // Default alignment parameters
    localparam int unsigned DEF_WORD_ALIGN     = 64;
    localparam int unsigned DEF_PAGE_ALIGN_MAX = 2 * 1024 * 1024;
    localparam int unsigned DEF_SIZE_FACTOR    = 8;
    localparam int unsigned DEF_POINTER_BYTES  = 8;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== design/allocation_alignment_select.sv =====
// When no lcm is needed the result passes through S_FIN to the output register. Each
// lcm runs Euclid on the shared 32-bit divider, one divide per remainder step, then
// one more divide, a multiply and a saturate. The large tier with a nonzero request
// chains two lcms. Throughput: one transaction at a time; o_stall is high from accept
// until the result is registered.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module allocation_alignment_select #(
    parameter int unsigned WORD_ALIGN     = aag_pkg::DEF_WORD_ALIGN,
    parameter int unsigned PAGE_ALIGN_MAX = aag_pkg::DEF_PAGE_ALIGN_MAX,
    parameter int unsigned SIZE_FACTOR    = aag_pkg::DEF_SIZE_FACTOR,
    parameter int unsigned POINTER_BYTES  = aag_pkg::DEF_POINTER_BYTES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [aag_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [aag_pkg::REQ_W-1:0]  i_requested_align,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [aag_pkg::OUT_W-1:0]       o_chosen_align
);
    import aag_pkg::*;

    localparam longint unsigned BIG_L = longint'(SIZE_FACTOR) * longint'(PAGE_ALIGN_MAX);
    localparam longint unsigned MID_L = longint'(SIZE_FACTOR) * longint'(WORD_ALIGN);
    localparam logic [SIZE_W-1:0] BIG_TH = SIZE_W'(BIG_L);
    localparam logic [SIZE_W-1:0] MID_TH = SIZE_W'(MID_L);
    localparam logic [DIV_W-1:0]  WA     = DIV_W'(WORD_ALIGN);
    localparam logic [DIV_W-1:0]  PA     = DIV_W'(PAGE_ALIGN_MAX);
    localparam logic [DIV_W-1:0]  PB     = DIV_W'(POINTER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_START,
        S_GCD_WAIT,
        S_Q_START,
        S_Q_WAIT,
        S_MUL,
        S_SAT,
        S_FIN
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out;
    logic [OUT_W-1:0]  r_res;
    logic              r_last;
    logic [DIV_W-1:0]  r_x;
    logic [DIV_W-1:0]  r_y;
    logic [DIV_W-1:0]  r_a;
    logic [DIV_W-1:0]  r_b;
    logic [DIV_W-1:0]  r_q;
    logic [PROD_W-1:0] r_prod;

    logic              in_accept;
    logic              big;
    logic              mid;
    logic              req_zero;
    logic [DIV_W-1:0]  req_ext;
    logic [OUT_W-1:0]  lcm_val;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    aag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        in_accept = i_valid && (r_state == S_IDLE);
        big       = (i_request_size >= BIG_TH);
        mid       = (i_request_size >= MID_TH);
        req_zero  = (i_requested_align == '0);
        req_ext   = DIV_W'(i_requested_align);
        lcm_val   = (r_prod[PROD_W-1:OUT_W] != '0) ? MASK48 : r_prod[OUT_W-1:0];

        div_req.start    = ((r_state == S_GCD_START) && (r_b != '0))
                           || (r_state == S_Q_START);
        div_req.dividend = (r_state == S_Q_START) ? r_x : r_a;
        div_req.divisor  = (r_state == S_Q_START) ? r_a : r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (!big && !mid) begin
                            if (req_zero) begin
                                r_res   <= OUT_W'(PB);
                                r_state <= S_FIN;
                            end else begin
                                r_x     <= req_ext;
                                r_a     <= req_ext;
                                r_y     <= PB;
                                r_b     <= PB;
                                r_last  <= 1'b1;
                                r_state <= S_GCD_START;
                            end
                        end else if (req_zero) begin
                            if (big) begin
                                r_x     <= WA;
                                r_a     <= WA;
                                r_y     <= PA;
                                r_b     <= PA;
                                r_last  <= 1'b1;
                                r_state <= S_GCD_START;
                            end else begin
                                r_res   <= OUT_W'(WA);
                                r_state <= S_FIN;
                            end
                        end else begin
                            // large tier chains a second lcm with the page alignment
                            r_x     <= req_ext;
                            r_a     <= req_ext;
                            r_y     <= WA;
                            r_b     <= WA;
                            r_last  <= !big;
                            r_state <= S_GCD_START;
                        end
                    end
                end
                S_GCD_START: begin
                    r_state <= (r_b == '0) ? S_Q_START : S_GCD_WAIT;
                end
                S_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        r_a     <= r_b;
                        r_b     <= div_rsp.rem;
                        r_state <= S_GCD_START;
                    end
                end
                S_Q_START: begin
                    r_state <= S_Q_WAIT;
                end
                S_Q_WAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_q * r_y;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (r_last) begin
                        r_res   <= lcm_val;
                        r_state <= S_FIN;
                    end else begin
                        // the word-tier lcm stays below 2^32, so no saturation here
                        r_x     <= lcm_val[DIV_W-1:0];
                        r_a     <= lcm_val[DIV_W-1:0];
                        r_y     <= PA;
                        r_b     <= PA;
                        r_last  <= 1'b1;
                        r_state <= S_GCD_START;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_chosen_align = r_out;

endmodule

`default_nettype wire

// ===== design/aag_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on aag_pkg for the operand width and request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module aag_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aag_pkg::t_div_req i_req,
    output aag_pkg::t_div_rsp      o_rsp
);
    import aag_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quot;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   shifted;
    logic             fits;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quot[DIV_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        // a failed trial leaves the top bit clear, so the low bits are the remainder
        n_rem   = fits ? DIV_W'(shifted - {1'b0, r_dvs}) : shifted[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// ===== design/aag_checker.sv =====
// Port-level checks for allocation_alignment_select, bound to the top level.
// Depends on aag_pkg for the port widths.
`timescale 1ns / 1ps
`default_nettype none

module aag_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [aag_pkg::OUT_W-1:0]  o_chosen_align
);
    import aag_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_chosen_align))
        else $error("stalled result changed");

    // every alignment is at least one byte
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chosen_align != '0))
        else $error("zero alignment delivered");

    // an accepted transaction keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // a new result only appears from a transaction in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a transaction in flight");

endmodule

bind allocation_alignment_select aag_checker u_aag_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_chosen_align (o_chosen_align)
);

`default_nettype wire

// ===== tb/allocation_alignment_select_tb.sv =====
// Self-checking testbench for allocation_alignment_select: directed tier boundaries,
// then random requests under valid/stall idling, checked by an in-bench alignment predictor.
// Depends on aag_pkg and allocation_alignment_select at default parameters.
`timescale 1ns / 1ps

module allocation_alignment_select_tb;

    import aag_pkg::*;

    localparam longint unsigned WORD_A = DEF_WORD_ALIGN;
    localparam longint unsigned PAGE_A = DEF_PAGE_ALIGN_MAX;
    localparam longint unsigned PTR_A  = DEF_POINTER_BYTES;
    localparam longint unsigned MID_SIZE = DEF_SIZE_FACTOR * WORD_A;
    localparam longint unsigned BIG_SIZE = DEF_SIZE_FACTOR * PAGE_A;
    localparam longint unsigned LIMIT48  = (64'd1 << OUT_W) - 1;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_ITEMS   = 130;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_LIMIT  = 50000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [SIZE_W-1:0]    i_request_size = '0;
    logic [REQ_W-1:0]     i_requested_align = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [OUT_W-1:0]     o_chosen_align;

    allocation_alignment_select DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_request_size    (i_request_size),
        .i_requested_align (i_requested_align),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_chosen_align    (o_chosen_align)
    );

    // Expected alignments, oldest first, with the predictor that produces them
    class align_scoreboard;
        logic [OUT_W-1:0] expected_align_q[$];
        int errors = 0;
        int checked = 0;

        function longint unsigned common_divisor(longint unsigned a, longint unsigned b);
            longint unsigned r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Clamp to 48 bits rather than wrap
        function longint unsigned common_multiple(longint unsigned a, longint unsigned b);
            longint unsigned q;
            if (a == 0 || b == 0)
                return 0;
            q = a / common_divisor(a, b);
            if (q > LIMIT48 / b)
                return LIMIT48;
            return q * b;
        endfunction

        function logic [OUT_W-1:0] predict_align(logic [SIZE_W-1:0] sz, logic [REQ_W-1:0] ra);
            longint unsigned req;
            longint unsigned word;
            longint unsigned res;
            req  = 64'(ra);
            word = (req == 0) ? WORD_A : common_multiple(req, WORD_A);
            if (sz >= BIG_SIZE)
                res = common_multiple(word, PAGE_A);
            else if (sz >= MID_SIZE)
                res = word;
            else if (req != 0)
                res = common_multiple(req, PTR_A);
            else
                res = PTR_A;
            return res[OUT_W-1:0];
        endfunction

        function void note_request(logic [SIZE_W-1:0] sz, logic [REQ_W-1:0] ra);
            expected_align_q.push_back(predict_align(sz, ra));
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            checked++;
            if (expected_align_q.size() == 0) begin
                $error("chosen_align: expected nothing, actual %0d", got);
                errors++;
                return;
            end
            want = expected_align_q.pop_front();
            if (got !== want) begin
                $error("chosen_align: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_align_q.size();
        endfunction
    endclass

    align_scoreboard sb = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int n_small = 0, n_medium = 0, n_large = 0, n_auto = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: check accepted transactions, stall in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && !i_stall)
                sb.check_result(o_chosen_align);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one transaction and hold it until accepted; maybe idle afterwards
    task automatic drive_request(input logic [SIZE_W-1:0] sz, input logic [REQ_W-1:0] ra);
        i_valid           <= 1'b1;
        i_request_size    <= sz;
        i_requested_align <= ra;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_request(sz, ra);
        if (sz >= BIG_SIZE)
            n_large++;
        else if (sz >= MID_SIZE)
            n_medium++;
        else
            n_small++;
        if (ra == 0)
            n_auto++;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        longint unsigned r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return SIZE_W'($urandom_range(0, MID_SIZE - 1));
            3, 4, 5: return SIZE_W'(MID_SIZE + r % (BIG_SIZE - MID_SIZE));
            6, 7:    return r[SIZE_W-1:0];
            8: begin
                case ($urandom_range(0, 5))
                    0: return SIZE_W'(MID_SIZE - 1);
                    1: return SIZE_W'(MID_SIZE);
                    2: return SIZE_W'(BIG_SIZE - 1);
                    3: return SIZE_W'(BIG_SIZE);
                    4: return '0;
                    default: return '1;
                endcase
            end
            default: return SIZE_W'(BIG_SIZE + $urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_align();
        logic [REQ_W-1:0] r;
        r = REQ_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3, 4: return r;
            5:       return REQ_W'(1 << $urandom_range(0, REQ_W - 1));
            6:       return REQ_W'($urandom_range(1, 16383) * 64);
            7:       return REQ_W'($urandom_range(1, 255));
            8:       return ($urandom_range(0, 1) == 0) ? '1 : REQ_W'(1);
            default: return r | REQ_W'(1);
        endcase
    endfunction

    initial begin
        int drain_cycles;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tier boundaries, automatic alignment and extreme requests
        drive_request(0, 0);
        drive_request(0, 1);
        drive_request(0, '1);
        drive_request(MID_SIZE - 1, 3);
        drive_request(MID_SIZE, 0);
        drive_request(MID_SIZE, 1);
        drive_request(MID_SIZE, '1);
        drive_request(BIG_SIZE - 1, 64);
        drive_request(BIG_SIZE, 0);
        drive_request(BIG_SIZE, 1);
        drive_request(BIG_SIZE, '1);
        drive_request('1, 0);
        drive_request('1, '1);
        drive_request(100, 8);
        drive_request(100, 12);
        drive_request(1000, 96);
        drive_request(1000, 20'h80000);
        drive_request(48'd1 << 30, 20'h80000);
        drive_request(48'd1 << 40, 3);
        drive_request(7, 4);
        drive_request(600, 127);
        drive_request(BIG_SIZE + 5, 999983);

        // Let everything drain, then back up the block behind a long receiver hold
        wait_drained();
        @(posedge i_clk);
        long_hold_req = 1'b1;
        tx_idle_on = 1'b0;
        repeat (6) drive_request(pick_size(), pick_align());
        tx_idle_on = 1'b1;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            drive_request(pick_size(), pick_align());
            if (k % 250 == 249) begin
                wait_drained();
                @(posedge i_clk);
            end
        end

        // Closing stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < CALM_ITEMS; k++)
            drive_request(pick_size(), pick_align());

        i_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (sb.pending() != 0) begin
            $error("chosen_align: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (50) @(posedge i_clk);

        $display("Covered %0d small, %0d medium and %0d large requests (%0d automatic).",
                 n_small, n_medium, n_large, n_auto);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
